[sv/shp_pkg.sv]
// Shared types and constants for the shortest path search block.
// Holds field widths, command and register codes, controller states and datapath ops.
// No dependencies; every other file of the block imports it.
package shp_pkg;

	localparam int NODES_DEF       = 16;
	localparam int WEIGHT_BITS_DEF = 8;
	localparam int MAX_RESULTS     = 15;

	localparam int CMD_W      = 2;
	localparam int NODE_W     = 4;
	localparam int WEIGHT_W   = 8;
	localparam int DIST_W     = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [NODE_W-1:0] START_RST  = 4'd0;
	localparam logic [NODE_W-1:0] TARGET_RST = 4'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_EDGE   = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START  = 1'b0,
		REG_TARGET = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_PICK,
		ST_DECIDE,
		ST_RELAX,
		ST_DRAIN,
		ST_BT_READ,
		ST_BT_EMIT,
		ST_FAIL,
		ST_SELF
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_EDGE,
		OP_INIT,
		OP_SCAN,
		OP_DECIDE,
		OP_RELAX,
		OP_DRAIN,
		OP_BT_READ,
		OP_BT_EMIT,
		OP_FAIL,
		OP_SELF
	} dp_op_t;

	typedef struct packed {
		logic clr_last;
		logic idx_last;
		logic have;
		logic u_is_t;
		logic oor;
		logic s_eq_t;
		logic out_free;
		logic bt_end;
	} dp_status_t;

endpackage

[sv/shp_ctrl.sv]
// Sequencer for the shortest path search block.
// Walks clear, edge write, select, relax and backtrack phases; drives shp_dp by op code.
// Depends on shp_pkg.
module shp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [shp_pkg::CMD_W-1:0] in_cmd,
	input  shp_pkg::dp_status_t       status,
	output logic                      in_ready,
	output shp_pkg::dp_op_t           op
);
	import shp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd_t'(in_cmd))
						CMD_CLEAR:  state_d = ST_CLEAR;
						CMD_SEARCH: state_d = ST_START;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_START:  state_d = status.oor ? ST_FAIL : ST_SCAN;
			ST_SCAN: begin
				if (status.idx_last) state_d = ST_PICK;
			end
			ST_PICK:   state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!status.have) begin
					state_d = ST_FAIL;
				end else if (status.u_is_t) begin
					state_d = status.s_eq_t ? ST_SELF : ST_BT_READ;
				end else begin
					state_d = ST_RELAX;
				end
			end
			ST_RELAX: begin
				if (status.idx_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:   state_d = ST_SCAN;
			ST_BT_READ: state_d = ST_BT_EMIT;
			ST_BT_EMIT: begin
				if (status.out_free) state_d = status.bt_end ? ST_IDLE : ST_BT_READ;
			end
			ST_FAIL, ST_SELF: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		op       = OP_NONE;
		case (state_q)
			ST_CLEAR:   op = OP_CLEAR;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && cmd_t'(in_cmd) == CMD_EDGE) op = OP_EDGE;
			end
			ST_START:   op = OP_INIT;
			ST_SCAN:    op = OP_SCAN;
			ST_PICK:    op = OP_NONE;
			ST_DECIDE:  op = OP_DECIDE;
			ST_RELAX:   op = OP_RELAX;
			ST_DRAIN:   op = OP_DRAIN;
			ST_BT_READ: op = OP_BT_READ;
			ST_BT_EMIT: op = OP_BT_EMIT;
			ST_FAIL:    op = OP_FAIL;
			ST_SELF:    op = OP_SELF;
			default:    op = OP_NONE;
		endcase
	end

endmodule

[sv/shp_dp.sv]
// Datapath of the shortest path search block: edge memory, distance and predecessor
// memories, reached/settled flags, scan and relax stages, output register.
// Depends on shp_pkg; sequenced by shp_ctrl.
module shp_dp #(
	parameter int NODES       = shp_pkg::NODES_DEF,
	parameter int WEIGHT_BITS = shp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  shp_pkg::dp_op_t                op,
	input  logic [shp_pkg::NODE_W-1:0]     edge_from,
	input  logic [shp_pkg::NODE_W-1:0]     edge_to,
	input  logic [shp_pkg::WEIGHT_W-1:0]   edge_weight,
	input  logic                           cfg_valid,
	input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           found,
	output logic [shp_pkg::NODE_W-1:0]     path_from,
	output logic [shp_pkg::NODE_W-1:0]     path_to,
	output logic [shp_pkg::DIST_W-1:0]     path_distance,
	output logic                           last_edge,
	output shp_pkg::dp_status_t            status
);
	import shp_pkg::*;

	localparam int NB        = $clog2(NODES);
	localparam int DIST_BITS = NB + WEIGHT_BITS;
	localparam int EDGE_DEPTH = 1 << (2 * NB);

	logic [WEIGHT_BITS-1:0] edge_mem [EDGE_DEPTH];
	logic [DIST_BITS-1:0]   dist_mem [NODES];
	logic [NB-1:0]          pred_mem [NODES];

	logic [NODE_W-1:0]      start_q, target_q;
	logic [2*NB-1:0]        clr_cnt_q;
	logic [NB-1:0]          idx_q;
	logic                   sv_s1, rv_s1;
	logic [NB-1:0]          si_s1, ri_s1;
	logic                   have_q;
	logic [DIST_BITS-1:0]   best_q;
	logic [NB-1:0]          u_q, bv_q;
	logic [NODES-1:0]       reached_q, done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIST_BITS-1:0]   dist_rd_q;
	logic [NB-1:0]          pred_rd_q;
	logic [WEIGHT_BITS-1:0] edge_rd_q;
	logic                   out_valid_q;

	logic [NB-1:0]          s_idx, rd_addr;
	logic [DIST_BITS-1:0]   nd;
	logic                   edge_ok, cand, relax_upd, out_free, load;

	assign s_idx   = NB'(start_q);
	assign rd_addr = (op == OP_BT_READ || op == OP_BT_EMIT) ? bv_q : idx_q;
	assign edge_ok = (32'(edge_from) < 32'(NODES)) && (32'(edge_to) < 32'(NODES));
	assign nd      = best_q + DIST_BITS'(edge_rd_q);

	assign cand = sv_s1 && reached_q[si_s1] && !done_q[si_s1]
		&& (!have_q || dist_rd_q < best_q);
	assign relax_upd = rv_s1 && (edge_rd_q != '0) && !done_q[ri_s1]
		&& (!reached_q[ri_s1] || nd < dist_rd_q);

	assign out_free = !out_valid_q || out_ready;
	assign load = out_free && (op == OP_BT_EMIT || op == OP_FAIL || op == OP_SELF);

	assign status.clr_last = (clr_cnt_q == '1);
	assign status.idx_last = (idx_q == NB'(NODES - 1));
	assign status.have     = have_q;
	assign status.u_is_t   = (u_q == NB'(target_q));
	assign status.oor      = (32'(start_q) >= 32'(NODES)) || (32'(target_q) >= 32'(NODES));
	assign status.s_eq_t   = (start_q == target_q);
	assign status.out_free = out_free;
	assign status.bt_end   = (pred_rd_q == s_idx) || (cnt_q == CNT_W'(MAX_RESULTS - 1));

	// memories: one write port each, registered reads
	always_ff @(posedge clk) begin
		if (op == OP_CLEAR) begin
			edge_mem[clr_cnt_q] <= '0;
		end else if (op == OP_EDGE && edge_ok) begin
			edge_mem[{NB'(edge_from), NB'(edge_to)}] <= WEIGHT_BITS'(edge_weight);
		end
		if (op == OP_INIT) begin
			dist_mem[s_idx] <= '0;
			pred_mem[s_idx] <= s_idx;
		end else if (relax_upd) begin
			dist_mem[ri_s1] <= nd;
			pred_mem[ri_s1] <= u_q;
		end
		edge_rd_q <= edge_mem[{u_q, idx_q}];
		dist_rd_q <= dist_mem[rd_addr];
		pred_rd_q <= pred_mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		si_s1 <= idx_q;
		ri_s1 <= idx_q;
		if (cand) begin
			best_q <= dist_rd_q;
			u_q    <= si_s1;
		end
		if (op == OP_DECIDE) begin
			bv_q <= NB'(target_q);
		end else if (op == OP_BT_EMIT && load) begin
			bv_q <= pred_rd_q;
		end
		if (load) begin
			case (op)
				OP_BT_EMIT: begin
					found         <= 1'b1;
					path_from     <= NODE_W'(pred_rd_q);
					path_to       <= NODE_W'(bv_q);
					path_distance <= DIST_W'(dist_rd_q);
					last_edge     <= (pred_rd_q == s_idx);
				end
				OP_SELF: begin
					found         <= 1'b1;
					path_from     <= start_q;
					path_to       <= start_q;
					path_distance <= '0;
					last_edge     <= 1'b1;
				end
				default: begin
					found         <= 1'b0;
					path_from     <= start_q;
					path_to       <= target_q;
					path_distance <= '0;
					last_edge     <= 1'b1;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= START_RST;
			target_q    <= TARGET_RST;
			clr_cnt_q   <= '0;
			idx_q       <= '0;
			sv_s1       <= 1'b0;
			rv_s1       <= 1'b0;
			have_q      <= 1'b0;
			reached_q   <= '0;
			done_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (reg_idx_t'(cfg_index) == REG_START) begin
					start_q <= cfg_data;
				end else begin
					target_q <= cfg_data;
				end
			end
			if (op == OP_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;

			sv_s1 <= (op == OP_SCAN);
			rv_s1 <= (op == OP_RELAX);

			case (op)
				OP_INIT: begin
					idx_q     <= '0;
					have_q    <= 1'b0;
					cnt_q     <= '0;
					done_q    <= '0;
					reached_q <= NODES'(1) << s_idx;
				end
				OP_SCAN, OP_RELAX: idx_q <= idx_q + 1'b1;
				OP_DECIDE: begin
					idx_q  <= '0;
					have_q <= 1'b0;
					cnt_q  <= '0;
					if (have_q) done_q[u_q] <= 1'b1;
				end
				OP_DRAIN: idx_q <= '0;
				default: ;
			endcase

			if (cand) have_q <= 1'b1;
			if (relax_upd) reached_q[ri_s1] <= 1'b1;
			if (op == OP_BT_EMIT && load) cnt_q <= cnt_q + 1'b1;

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/shortest_path_search.sv]
// Top level of the single-pair shortest path search block.
// Joins the sequencer shp_ctrl and the datapath shp_dp; uses shp_pkg for widths and codes.
//
// Usage: after reset the block sweeps its edge memory to zero, one entry a cycle, over
// all 2^(2*ceil(log2 NODES)) entries (256 at 16 nodes), and takes no word until that is
// done; configuration writes are taken throughout. A clear command (tuser 0) repeats that
// sweep. Edge writes (tuser 1) stream at one word per clock. A search (tuser 2) runs
// Dijkstra from start_node to target_node: for every settled node that is not the target,
// the distance memory, with its one read port, is walked once to select the nearest open
// node and once to relax the outgoing edges of that node; the final round only selects.
// The search stops when the target settles. Path words leave from the target back to the
// start with cumulative distances; tlast marks the word leaving start. An unreachable
// target or an out-of-range start or target gives one word with found clear; start equal
// to target gives one zero-length word. At most 15 path words are emitted per search. The
// output register holds a finished word while the next input word is taken. Write
// start_node (index 0) and target_node (index 1) only while the block is idle.
module shortest_path_search #(
	parameter int NODES       = shp_pkg::NODES_DEF,
	parameter int WEIGHT_BITS = shp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [shp_pkg::IN_DATA_W-1:0]   s_tdata,   // edge_from[3:0], edge_to[7:4],
	                                                   // edge_weight[15:8]
	input  logic [shp_pkg::CMD_W-1:0]       s_tuser,   // command[1:0]
	// path words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [shp_pkg::OUT_DATA_W-1:0]  m_tdata,   // path_from[3:0], path_to[7:4],
	                                                   // path_distance[19:8], zero[23:20]
	output logic                            m_tuser,   // found
	output logic                            m_tlast,   // last_edge
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import shp_pkg::*;

	dp_op_t               op;
	dp_status_t           status;
	logic [NODE_W-1:0]    path_from, path_to;
	logic [DIST_W-1:0]    path_distance;

	// registers are always writable
	assign cfg_ready = 1'b1;

	shp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.status   (status),
		.in_ready (s_tready),
		.op       (op)
	);

	shp_dp #(
		.NODES       (NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.edge_from     (s_tdata[3:0]),
		.edge_to       (s_tdata[7:4]),
		.edge_weight   (s_tdata[15:8]),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.found         (m_tuser),
		.path_from     (path_from),
		.path_to       (path_to),
		.path_distance (path_distance),
		.last_edge     (m_tlast),
		.status        (status)
	);

	// pack the path word, low field first, pad to whole bytes
	assign m_tdata = {4'd0, path_distance, path_to, path_from};

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for shortest_path_search: streams clear, edge and search words and
// predicts every path word with its own Dijkstra search. Needs shp_pkg and the block's RTL.

typedef struct {
	logic                         found;
	logic [shp_pkg::NODE_W-1:0]   hop_from;
	logic [shp_pkg::NODE_W-1:0]   hop_to;
	logic [shp_pkg::DIST_W-1:0]   hop_dist;
	logic                         last;
} path_hop_t;

// Keeps its own copy of the edge store and endpoints, turns every accepted input word
// into the path words it should produce, and checks the words that leave the block.
class route_checker;
	logic [shp_pkg::WEIGHT_W-1:0] weight_mem [shp_pkg::NODES_DEF * shp_pkg::NODES_DEF];
	logic [shp_pkg::NODE_W-1:0]   src_node;
	logic [shp_pkg::NODE_W-1:0]   dst_node;
	path_hop_t                    pending_hops [$];
	int                           mismatches;
	int                           hops_seen;

	function new();
		foreach (weight_mem[i])
			weight_mem[i] = '0;
		src_node   = shp_pkg::START_RST;
		dst_node   = shp_pkg::TARGET_RST;
		mismatches = 0;
		hops_seen  = 0;
	endfunction

	task flag_mismatch(string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatches++;
	endtask

	function void set_reg(logic [shp_pkg::CFG_IDX_W-1:0] idx,
	                      logic [shp_pkg::CFG_DATA_W-1:0] val);
		if (idx == shp_pkg::REG_START)
			src_node = val;
		else
			dst_node = val;
	endfunction

	function void add_hop(logic found, logic [3:0] a, logic [3:0] b, int unsigned d,
	                      logic last);
		path_hop_t h;
		h.found    = found;
		h.hop_from = a;
		h.hop_to   = b;
		h.hop_dist = d[shp_pkg::DIST_W-1:0];
		h.last     = last;
		pending_hops.push_back(h);
	endfunction

	// Dijkstra from src_node to dst_node; lowest index wins a tie, strict improvement only.
	function void plan_route();
		int unsigned                dist_to [shp_pkg::NODES_DEF];
		bit                         settled [shp_pkg::NODES_DEF];
		bit                         seen [shp_pkg::NODES_DEF];
		logic [shp_pkg::NODE_W-1:0] pred [shp_pkg::NODES_DEF];
		int unsigned                best;
		int unsigned                nd;
		bit                         have;
		int                         u;
		int                         hops;
		logic [shp_pkg::NODE_W-1:0] v;
		logic [shp_pkg::NODE_W-1:0] p;
		logic [shp_pkg::WEIGHT_W-1:0] w;
		for (int i = 0; i < shp_pkg::NODES_DEF; i++) begin
			dist_to[i] = 0;
			settled[i] = 1'b0;
			seen[i]    = 1'b0;
			pred[i]    = '0;
		end
		seen[src_node] = 1'b1;
		pred[src_node] = src_node;
		forever begin
			have = 1'b0;
			best = 0;
			u    = 0;
			for (int i = 0; i < shp_pkg::NODES_DEF; i++) begin
				if (seen[i] && !settled[i] && (!have || dist_to[i] < best)) begin
					have = 1'b1;
					best = dist_to[i];
					u    = i;
				end
			end
			if (!have) begin
				// target never reached
				add_hop(1'b0, src_node, dst_node, 0, 1'b1);
				return;
			end
			settled[u] = 1'b1;
			if (u == dst_node)
				break;
			for (int j = 0; j < shp_pkg::NODES_DEF; j++) begin
				w = weight_mem[u * shp_pkg::NODES_DEF + j];
				if (w != 0 && !settled[j]) begin
					nd = dist_to[u] + w;
					if (!seen[j] || nd < dist_to[j]) begin
						seen[j]    = 1'b1;
						dist_to[j] = nd;
						pred[j]    = u[shp_pkg::NODE_W-1:0];
					end
				end
			end
		end
		if (src_node == dst_node) begin
			add_hop(1'b1, src_node, src_node, 0, 1'b1);
			return;
		end
		// walk back from the target, one path word per edge
		v    = dst_node;
		hops = 0;
		while (v != src_node && hops < shp_pkg::MAX_RESULTS) begin
			p = pred[v];
			add_hop(1'b1, p, v, dist_to[v], p == src_node);
			hops++;
			v = p;
		end
	endfunction

	function void take_word(logic [shp_pkg::CMD_W-1:0] cmd,
	                        logic [shp_pkg::IN_DATA_W-1:0] data);
		case (cmd)
			shp_pkg::CMD_CLEAR: begin
				foreach (weight_mem[i])
					weight_mem[i] = '0;
			end
			shp_pkg::CMD_EDGE: weight_mem[{data[3:0], data[7:4]}] = data[15:8];
			shp_pkg::CMD_SEARCH: plan_route();
			default: ;
		endcase
	endfunction

	task check_hop(logic found, logic [shp_pkg::OUT_DATA_W-1:0] data, logic last);
		path_hop_t e;
		if (pending_hops.size() == 0) begin
			flag_mismatch($sformatf("path word %h found=%b last=%b with none expected",
			                        data, found, last));
			return;
		end
		e = pending_hops.pop_front();
		if (found !== e.found)
			flag_mismatch($sformatf("word %0d found %b, expected %b", hops_seen, found, e.found));
		if (data[3:0] !== e.hop_from)
			flag_mismatch($sformatf("word %0d path_from %0d, expected %0d", hops_seen,
			                        data[3:0], e.hop_from));
		if (data[7:4] !== e.hop_to)
			flag_mismatch($sformatf("word %0d path_to %0d, expected %0d", hops_seen,
			                        data[7:4], e.hop_to));
		if (data[19:8] !== e.hop_dist)
			flag_mismatch($sformatf("word %0d path_distance %0d, expected %0d", hops_seen,
			                        data[19:8], e.hop_dist));
		if (last !== e.last)
			flag_mismatch($sformatf("word %0d last_edge %b, expected %b", hops_seen, last, e.last));
		hops_seen++;
	endtask

	task flag_leftovers();
		if (pending_hops.size() != 0)
			flag_mismatch($sformatf("%0d path words never arrived", pending_hops.size()));
	endtask
endclass

module tb_top;
	import shp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEMS_TOTAL    = 260;
	localparam int DIRECTED_ITEMS = 16;
	localparam int PHASES         = 8;
	// longest quiet stretch of a correct run: clear sweep or full search, plus emit
	localparam int SETTLE_CYCLES  = 800;
	localparam int HOLD_CYCLES    = 3000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;    // edge_from[3:0], edge_to[7:4], edge_weight[15:8]
	logic [CMD_W-1:0]      s_tuser;    // command[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;    // path_from[3:0], path_to[7:4], path_distance[19:8]
	logic                  m_tuser;    // found
	logic                  m_tlast;    // last_edge
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	route_checker sb;

	// idling knobs, percent of cycles
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	bit long_hold     = 1'b0;
	int words_sent    = 0;
	int quiet_cycles  = 0;
	logic [NODE_W-1:0] cur_start  = START_RST;
	logic [NODE_W-1:0] cur_target = TARGET_RST;

	shortest_path_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: sample every handshake on the edge, feed the checker, run the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_word(s_tuser, s_tdata);
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (m_tvalid && m_tready)
				sb.check_hop(m_tuser, m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no word moved for %0d cycles", $realtime, quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here so the block backs up.
	initial begin
		int held;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				long_hold = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			2, 3, 4, 5: return 8'($urandom_range(1, 4));  // small weights force ties
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// Offer one input word and hold it until taken. Keep tvalid high into the next word
	// when no gap is drawn, so it never drops and rises in one step.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] a,
	                         input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] wt);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {wt, b, a};
		do
			@(posedge clk);
		while (!s_tready);
		if (cmd != CMD_UNUSED)
			words_sent++;
	endtask

	// Drop the input, wait for every expected path word, then let a clear or search finish.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_hops.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both endpoints back to back in random order; hold cfg_valid across the pair.
	task automatic set_endpoints(input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] t);
		bit target_first;
		target_first = $urandom_range(1);
		cfg_valid <= 1'b1;
		cfg_index <= target_first ? REG_TARGET : REG_START;
		cfg_data  <= target_first ? t : s;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_index <= target_first ? REG_START : REG_TARGET;
		cfg_data  <= target_first ? s : t;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		cur_start  = s;
		cur_target = t;
	endtask

	task automatic run_directed();
		send_word(CMD_SEARCH, 4'hF, 4'hF, 8'hFF);   // empty graph: unreachable target
		send_word(CMD_UNUSED, 4'hF, 4'hF, 8'hFF);   // unused command, ignored
		send_word(CMD_EDGE, 4'hF, 4'hF, 8'hFF);
		send_word(CMD_EDGE, 4'h0, 4'h1, 8'h00);     // weight zero: no edge
		send_word(CMD_EDGE, 4'h0, 4'h1, 8'h01);
		send_word(CMD_EDGE, 4'h1, 4'h8, 8'h01);
		send_word(CMD_EDGE, 4'h0, 4'h8, 8'h02);
		send_word(CMD_SEARCH, 4'h0, 4'h0, 8'h00);   // equal cost: the direct edge stays
		send_word(CMD_EDGE, 4'h0, 4'h8, 8'hFF);
		send_word(CMD_SEARCH, 4'h5, 4'hA, 8'h5A);   // two hops through node 1
		send_word(CMD_EDGE, 4'h1, 4'h8, 8'h00);     // remove the middle edge
		send_word(CMD_EDGE, 4'h8, 4'h0, 8'h07);     // edge back into a settled start
		send_word(CMD_EDGE, 4'h3, 4'h3, 8'h09);     // self loop
		send_word(CMD_SEARCH, 4'hA, 4'h5, 8'hA5);   // single heavy edge
		send_word(CMD_CLEAR, 4'hF, 4'hF, 8'hFF);
		send_word(CMD_SEARCH, 4'h0, 4'h0, 8'h00);   // unreachable again after the clear
	endtask

	// One graph episode: maybe clear, maybe lay a chain from start to target, scatter extra
	// edges, maybe some noise, then search.
	task automatic random_episode();
		logic [NODE_W-1:0] order [NODES_DEF];
		logic [NODE_W-1:0] here;
		logic [NODE_W-1:0] there;
		logic [NODE_W-1:0] tmp;
		int                hops;
		int                extras;
		int                k;
		int                j;
		bit                heavy;
		hops = ($urandom_range(4) == 0) ? MAX_RESULTS : $urandom_range(1, 5);
		if ($urandom_range(3) == 0 || (hops == MAX_RESULTS && $urandom_range(1) == 1))
			send_word(CMD_CLEAR, 4'($urandom), 4'($urandom), 8'($urandom));
		if ($urandom_range(2) != 0) begin
			heavy = ($urandom_range(5) == 0);
			for (k = 0; k < NODES_DEF; k++)
				order[k] = k[NODE_W-1:0];
			for (k = NODES_DEF - 1; k > 0; k--) begin
				j        = $urandom_range(k);
				tmp      = order[k];
				order[k] = order[j];
				order[j] = tmp;
			end
			here = cur_start;
			k    = 0;
			for (int h = 1; h < hops; h++) begin
				// skip the endpoints so the chain visits distinct nodes
				while (order[k] == cur_start || order[k] == cur_target)
					k++;
				there = order[k];
				k++;
				send_word(CMD_EDGE, here, there, heavy ? 8'd255 : pick_weight());
				here = there;
			end
			send_word(CMD_EDGE, here, cur_target, heavy ? 8'd255 : pick_weight());
		end
		extras = $urandom_range(0, 6);
		repeat (extras)
			send_word(CMD_EDGE, 4'($urandom), 4'($urandom), pick_weight());
		if ($urandom_range(7) == 0)
			send_word(CMD_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom));
		send_word(CMD_SEARCH, 4'($urandom), 4'($urandom), 8'($urandom));
	endtask

	initial begin
		int                phase;
		int                goal;
		logic [NODE_W-1:0] s;
		logic [NODE_W-1:0] t;
		sb = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= CMD_CLEAR;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_START;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset endpoints, no idling
		run_directed();

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				// pause the sender until the block is idle, then move the endpoints
				wait_drained();
				case (phase)
					1: begin s = 4'd0;  t = 4'd15; end
					2: begin s = 4'd15; t = 4'd0;  end
					3: begin s = 4'd9;  t = 4'd9;  end
					6: begin s = 4'd15; t = 4'd14; end
					default: begin
						s = 4'($urandom);
						t = 4'($urandom);
					end
				endcase
				set_endpoints(s, t);
			end
			case (phase % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
				default: begin src_idle_pct = 36; snk_stall_pct = 36; end
			endcase
			// hold the output off while the sender keeps pushing
			if (phase == 1)
				long_hold = 1'b1;
			goal = words_sent + (ITEMS_TOTAL - DIRECTED_ITEMS) / PHASES;
			while (words_sent < goal)
				random_episode();
		end

		wait_drained();
		sb.flag_leftovers();
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
